// ===== rtl/crd_pkg.sv =====
// Shared constants and types of the cell raster draw engine.
package crd_pkg;

   // Frame buffer geometry
   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 64;
   localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // Field and register widths
   localparam int KIND_W     = 3;
   localparam int COORD_W    = 16;
   localparam int RAD_W      = 8;
   localparam int ATTR_W     = 16;
   localparam int CELL_W     = ATTR_W + 1;
   localparam int CNT_W      = 14;
   localparam int FW_W       = 8;
   localparam int FH_W       = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Signed width for clipping arithmetic on coordinates and radius
   localparam int BND_W = COORD_W + 2;
   // Width of the row-times-width product plus column
   localparam int PROD_W = FW_W + FH_W;
   localparam int IDX_W  = (ADDR_W > PROD_W) ? ADDR_W : PROD_W;
   // Width of squared distances
   localparam int SQ_W = 2 * RAD_W + 2;

   // Register reset values
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(128);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(64);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Command codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PLOT = 3'd0,
      KIND_FILL = 3'd1,
      KIND_RING = 3'd2,
      KIND_DISC = 3'd3,
      KIND_READ = 3'd4
   } kind_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_RDWAIT
   } state_type;

endpackage

// ===== rtl/cell_raster_draw_engine.sv =====
// Top level of the cell raster draw engine: command sequencer around the cell store.
//
// Keeps a character-cell frame buffer (glyph flag plus 16-bit attribute per cell)
// in one single-port RAM. A command item is taken at a rising edge where start
// is high and busy is low. Kinds: plot, fill rectangle, circle ring, filled
// circle, read cell. Each item gives exactly one result, shown for one cycle
// with rsp_valid high; the receiver cannot stall, so results are never held.
// Draw commands walk the clipped bounding box one cell per cycle through the
// RAM write port after a setup step, and the result is shown in the cycle
// after the last cell. A box that clips to nothing answers in the cycle after
// start. A read goes through setup, RAM read and data capture to its result.
// busy is low again in the cycle the result is shown, so a new item may enter
// then. The single RAM port sets the rate of one cell per cycle.
// Reset clears the frame size registers to 128 by 64 and runs a clearing pass
// that zeroes all CELL_COUNT (8192) entries, one per cycle; busy stays high
// during the pass. Size writes on the csr_ port are taken at any time.
module cell_raster_draw_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [crd_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [crd_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [crd_pkg::COORD_W-1:0] req_y_pos,
   input  logic signed [crd_pkg::COORD_W-1:0] req_x_end,
   input  logic signed [crd_pkg::COORD_W-1:0] req_y_end,
   input  logic [crd_pkg::RAD_W-1:0]         req_radius,
   input  logic [crd_pkg::ATTR_W-1:0]        req_color,
   output logic                              rsp_valid,
   output logic [crd_pkg::CNT_W-1:0]         rsp_cells_written,
   output logic                              rsp_read_glyph_set,
   output logic [crd_pkg::ATTR_W-1:0]        rsp_read_attribute,
   input  logic                              csr_we,
   input  logic [crd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import crd_pkg::*;

   // Sequencer and clearing pass
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   // Frame size registers and the size in use
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;
   logic [FW_W-1:0] w_eff;
   logic [FH_W-1:0] h_eff;

   // Walk position and bounds
   logic [FW_W-1:0] x_ff, x_in, x_lo_ff, x_hi_ff;
   logic [FH_W-1:0] y_ff, y_in, y_hi_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Command payload held during the walk
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic [2*RAD_W-1:0]        outer_ff, inner_ff;
   logic                      circle_ff, ring_ff;
   logic [ATTR_W-1:0]         color_ff;

   // Result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_glyph_ff, rsp_glyph_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;

   // Setup logic
   logic signed [BND_W-1:0] xp, yp, xe, ye, rr, wl, hl;
   logic signed [BND_W-1:0] raw_xlo, raw_xhi, raw_ylo, raw_yhi;
   logic signed [BND_W-1:0] bx_lo, bx_hi, by_lo, by_hi;
   logic                    box_ok;
   logic                    load;
   logic [RAD_W-1:0]        r_inner;
   logic [2*RAD_W-1:0]      outer_in, inner_in;

   // Walk logic
   logic signed [BND_W-1:0] dx_full, dy_full;
   logic signed [RAD_W:0]   dx, dy;
   logic signed [SQ_W-1:0]  dx2, dy2;
   logic [SQ_W-1:0]         d2;
   logic                    hit;
   logic                    last_x, last_cell;
   logic [PROD_W-1:0]       row_base;
   logic [IDX_W-1:0]        cell_idx;
   logic [ADDR_W-1:0]       cell_addr;

   // RAM port
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   // Clamp the size registers to the buffer geometry
   always_comb begin
      w_eff = (32'(frame_width_ff) < MAX_WIDTH) ? frame_width_ff : FW_W'(MAX_WIDTH);
      h_eff = (32'(frame_height_ff) < MAX_HEIGHT) ? frame_height_ff : FH_W'(MAX_HEIGHT);
   end

   // Size register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FH_W-1:0];
         endcase
      end
   end

   // Work out the clipped box of an incoming command
   always_comb begin
      xp = BND_W'(req_x_pos);
      yp = BND_W'(req_y_pos);
      xe = BND_W'(req_x_end);
      ye = BND_W'(req_y_end);
      rr = signed'(BND_W'(req_radius));
      wl = signed'(BND_W'(w_eff));
      hl = signed'(BND_W'(h_eff));
      unique case (req_kind)
         KIND_PLOT, KIND_READ: begin
            raw_xlo = xp;
            raw_xhi = xp;
            raw_ylo = yp;
            raw_yhi = yp;
         end
         KIND_FILL: begin
            raw_xlo = xp;
            raw_xhi = xe - BND_W'(1);
            raw_ylo = yp;
            raw_yhi = ye - BND_W'(1);
         end
         KIND_RING, KIND_DISC: begin
            raw_xlo = xp - rr;
            raw_xhi = xp + rr;
            raw_ylo = yp - rr;
            raw_yhi = yp + rr;
         end
         default: begin
            // unused kinds give an empty box
            raw_xlo = '0;
            raw_xhi = '1;
            raw_ylo = '0;
            raw_yhi = '1;
         end
      endcase
      bx_lo  = (raw_xlo < 0) ? '0 : raw_xlo;
      by_lo  = (raw_ylo < 0) ? '0 : raw_ylo;
      bx_hi  = (raw_xhi > wl - BND_W'(1)) ? wl - BND_W'(1) : raw_xhi;
      by_hi  = (raw_yhi > hl - BND_W'(1)) ? hl - BND_W'(1) : raw_yhi;
      box_ok = (bx_lo <= bx_hi) && (by_lo <= by_hi);

      // outer and inner squared radius for the circle test
      r_inner  = (req_radius == '0) ? '0 : req_radius - RAD_W'(1);
      outer_in = (2*RAD_W)'(req_radius) * (2*RAD_W)'(req_radius);
      inner_in = (2*RAD_W)'(r_inner) * (2*RAD_W)'(r_inner);
   end

   // Distance test and address of the current cell
   always_comb begin
      dx_full   = signed'(BND_W'(x_ff)) - BND_W'(cx_ff);
      dy_full   = signed'(BND_W'(y_ff)) - BND_W'(cy_ff);
      dx        = dx_full[RAD_W:0];
      dy        = dy_full[RAD_W:0];
      dx2       = SQ_W'(dx) * SQ_W'(dx);
      dy2       = SQ_W'(dy) * SQ_W'(dy);
      d2        = SQ_W'(dx2[2*RAD_W:0]) + SQ_W'(dy2[2*RAD_W:0]);
      hit       = !circle_ff ||
                  ((d2 <= SQ_W'(outer_ff)) && (!ring_ff || (d2 >= SQ_W'(inner_ff))));
      last_x    = (x_ff == x_hi_ff);
      last_cell = last_x && (y_ff == y_hi_ff);
      row_base  = PROD_W'(y_ff) * PROD_W'(w_eff);
      cell_idx  = IDX_W'(row_base) + IDX_W'(x_ff);
      cell_addr = cell_idx[ADDR_W-1:0];
   end

   // Next state, RAM control and result
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_attr_in  = rsp_attr_ff;
      ram_we       = 1'b0;
      ram_addr     = cell_addr;
      ram_wdata    = {1'b1, color_ff};
      busy         = 1'b1;
      load         = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               load   = 1'b1;
               x_in   = bx_lo[FW_W-1:0];
               y_in   = by_lo[FH_W-1:0];
               cnt_in = '0;
               if (!box_ok) begin
                  // nothing in frame: answer with zeros
                  rsp_valid_in = 1'b1;
                  rsp_cnt_in   = '0;
                  rsp_glyph_in = 1'b0;
                  rsp_attr_in  = '0;
               end else if (req_kind == KIND_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            ram_we = hit;
            cnt_in = cnt_ff + CNT_W'(hit);
            if (last_cell) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = cnt_ff + CNT_W'(hit);
               rsp_glyph_in = 1'b0;
               rsp_attr_in  = '0;
               state_in     = ST_IDLE;
            end else if (last_x) begin
               x_in = x_lo_ff;
               y_in = y_ff + FH_W'(1);
            end else begin
               x_in = x_ff + FW_W'(1);
            end
         end
         ST_READ: begin
            // the RAM reads cell_addr at this edge
            state_in = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_cnt_in   = '0;
            rsp_glyph_in = ram_rdata[CELL_W-1];
            rsp_attr_in  = ram_rdata[ATTR_W-1:0];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk position, count and result payload
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      cnt_ff       <= cnt_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_attr_ff  <= rsp_attr_in;
   end

   // Hold the command payload for the walk
   always_ff @(posedge clock) begin
      if (load) begin
         cx_ff     <= req_x_pos;
         cy_ff     <= req_y_pos;
         x_lo_ff   <= bx_lo[FW_W-1:0];
         x_hi_ff   <= bx_hi[FW_W-1:0];
         y_hi_ff   <= by_hi[FH_W-1:0];
         outer_ff  <= outer_in;
         inner_ff  <= inner_in;
         circle_ff <= (req_kind == KIND_RING) || (req_kind == KIND_DISC);
         ring_ff   <= (req_kind == KIND_RING);
         color_ff  <= req_color;
      end
   end

   // Cell store
   crd_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cell_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cells_written  = rsp_cnt_ff;
   assign rsp_read_glyph_set = rsp_glyph_ff;
   assign rsp_read_attribute = rsp_attr_ff;

endmodule

// ===== rtl/crd_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module crd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, read the addressed entry every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/crd_check.sv =====
// Port-level checks of the cell raster draw engine, bound to the top level.
module crd_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [crd_pkg::CNT_W-1:0]   rsp_cells_written,
   input logic                        rsp_read_glyph_set,
   input logic [crd_pkg::ATTR_W-1:0]  rsp_read_attribute
);

   // Reset starts the clearing pass, so no item is taken right after it
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // An accepted item either keeps the block busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item neither busy nor answered");

   // A result only follows a busy cycle or an accepted item
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result without a command");

   // A drawn cell always carries the glyph flag
   a_attr_has_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_attribute != '0) |-> rsp_read_glyph_set)
      else $error("read attribute without glyph flag");

   // Read results that find a glyph never report written cells
   a_read_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_glyph_set |-> rsp_cells_written == '0)
      else $error("read result with nonzero count");

endmodule

bind cell_raster_draw_engine crd_check u_crd_check (.*);
